[hdl/hrp_pkg.sv]
// Shared types, operation codes and hash constants for the reuse predictor table.
package hrp_pkg;

  // Operation codes carried by each request
  localparam logic [1:0] OP_PREDICT    = 2'd0;
  localparam logic [1:0] OP_TRAIN_UP   = 2'd1;
  localparam logic [1:0] OP_TRAIN_DOWN = 2'd2;

  localparam int OP_W     = 2;
  localparam int PC_W     = 64;
  localparam int CNT_OUT_W = 5;

  // CRC hash: reflected polynomial, rounds split into steps of ROUNDS_PER_STEP
  localparam logic [PC_W-1:0] CRC_POLY = 64'h0000_0000_EDB8_8320;
  localparam int CRC_ROUNDS      = 32;
  localparam int ROUNDS_PER_STEP = 8;
  localparam int HASH_STEPS      = CRC_ROUNDS / ROUNDS_PER_STEP;
  // After all rounds only the low HASH_W bits can be nonzero
  localparam int HASH_W          = PC_W - CRC_ROUNDS;
  // Remainder by the table size: reciprocal multiply, subtract, one correction
  localparam int MOD_STEPS       = 3;
  localparam int STEP_W          = 3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PC_W-1:0] pc;
  } in_t;

  typedef struct packed {
    logic                 reuse_predicted;
    logic [CNT_OUT_W-1:0] counter_value;
  } out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_HASH,
    FE_MOD,
    FE_PUSH
  } fe_state_t;

  // Apply ROUNDS_PER_STEP rounds of the right-shifting CRC step
  function automatic logic [PC_W-1:0] crc_rounds(input logic [PC_W-1:0] v_in);
    logic [PC_W-1:0] v;
    v = v_in;
    for (int i = 0; i < ROUNDS_PER_STEP; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

[hdl/hrp_front.sv]
// Front end: accepts requests, hashes the program counter and reduces it to a table index.
module hrp_front
  import hrp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  input  logic             clearing,
  input  fifo_status_t     q_stat,
  output logic             q_push,
  output logic [OP_W-1:0]  q_op,
  output logic [IDX_W-1:0] q_idx
);

  // Reciprocal of the table size, scaled by 2^HASH_W and rounded down
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_ENTRIES);

  fe_state_t         state;
  fe_state_t         state_next;
  logic [STEP_W-1:0] step;
  logic [OP_W-1:0]   op;
  logic [PC_W-1:0]   hash;
  logic [HASH_W-1:0] quot;
  logic [IDX_W:0]    diff;
  logic [IDX_W-1:0]  rem;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE: begin
        if (in_valid && !clearing) state_next = FE_HASH;
      end
      FE_HASH: begin
        if (step == STEP_W'(HASH_STEPS - 1)) state_next = FE_MOD;
      end
      FE_MOD: begin
        if (step == STEP_W'(MOD_STEPS - 1)) state_next = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_stat.full) state_next = FE_IDLE;
      end
      default: state_next = FE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state)
      FE_IDLE: in_stall = clearing;
      FE_PUSH: q_push   = !q_stat.full;
      default: begin
        in_stall = 1'b1;
        q_push   = 1'b0;
      end
    endcase
  end

  assign q_op  = op;
  assign q_idx = rem;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else if (state == FE_HASH || state == FE_MOD) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Datapath: load, hash rounds, then reduce the hash by the table size
  always_ff @(posedge clk) begin
    case (state)
      FE_IDLE: begin
        if (in_valid && !clearing) begin
          op   <= in_data.op;
          hash <= in_data.pc;
        end
        rem <= '0;
      end
      FE_HASH: hash <= crc_rounds(hash);
      FE_MOD: begin
        case (step)
          // Estimate the quotient; it comes out low by at most one
          STEP_W'(0): begin
            quot <= HASH_W'((64'(hash[HASH_W-1:0]) * 64'(RECIP)) >> HASH_W);
          end
          // Subtract quotient times table size; the difference is below twice the size
          STEP_W'(1): begin
            diff <= (IDX_W+1)'(hash[HASH_W-1:0] - quot * HASH_W'(TABLE_ENTRIES));
          end
          // Correct the estimate with one compare and subtract
          default: begin
            rem <= (diff >= (IDX_W+1)'(TABLE_ENTRIES)) ?
                   IDX_W'(diff - (IDX_W+1)'(TABLE_ENTRIES)) : diff[IDX_W-1:0];
          end
        endcase
      end
      default: begin
        hash <= hash;
      end
    endcase
  end

endmodule

[hdl/hrp_queue.sv]
// Two-entry queue that decouples the hash front end from the table back end.
module hrp_queue
  import hrp_pkg::*;
#(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_status_t     stat
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_data   = slot[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule

[hdl/hrp_back.sv]
// Back end: counter table with valid bits, clearing pass, update and result register.
module hrp_back
  import hrp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048,
  parameter int COUNTER_MAX   = 31,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W = $clog2(COUNTER_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  fifo_status_t     q_stat,
  input  logic [OP_W-1:0]  q_op,
  input  logic [IDX_W-1:0] q_idx,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [CNT_W-1:0] MID  = CNT_W'((1 + COUNTER_MAX) / 2);
  localparam logic [CNT_W-1:0] CMAX = CNT_W'(COUNTER_MAX);

  // Each word holds the valid bit above the counter
  logic [CNT_W:0]     table_mem [TABLE_ENTRIES];
  logic [CNT_W:0]     rd_word;
  logic [IDX_W-1:0]   clr_idx;
  logic               busy;
  logic               done;
  logic [OP_W-1:0]    op;
  logic [IDX_W-1:0]   idx;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [CNT_W:0]     wdata;
  logic               is_train;
  logic               entry_ok;
  logic [CNT_W-1:0]   cnt_old;
  logic [CNT_W-1:0]   cnt_new;
  logic [EXT_W-1:0]   cnt_ext;
  out_t               result;

  assign pop  = !clearing && !busy && !q_stat.empty;
  assign done = busy && (!out_valid || !out_stall);

  // Compute prediction and updated counter from the stored word
  always_comb begin
    is_train = (op == OP_TRAIN_UP) || (op == OP_TRAIN_DOWN);
    entry_ok = rd_word[CNT_W];
    cnt_old  = entry_ok ? rd_word[CNT_W-1:0] : MID;
    cnt_new  = cnt_old;
    case (op)
      OP_TRAIN_UP:   cnt_new = (cnt_old < CMAX) ? cnt_old + CNT_W'(1) : CMAX;
      OP_TRAIN_DOWN: cnt_new = (cnt_old != '0) ? cnt_old - CNT_W'(1) : cnt_old;
      default:       cnt_new = cnt_old;
    endcase
    cnt_ext                = EXT_W'(cnt_new);
    result.reuse_predicted = !(entry_ok && (cnt_old < MID));
    result.counter_value   = cnt_ext[CNT_OUT_W-1:0];
  end

  // Select the table write: clearing pass or a training update
  always_comb begin
    we    = clearing || (done && is_train);
    waddr = clearing ? clr_idx : idx;
    wdata = clearing ? '0 : {1'b1, cnt_new};
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (we)  table_mem[waddr] <= wdata;
    if (pop) rd_word <= table_mem[q_idx];
  end

  // Hold the request being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      op  <= q_op;
      idx <= q_idx;
    end
  end

  // Control: clearing sweep, busy flag, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + IDX_W'(1);
        end
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_data <= result;
  end

`ifndef SYNTHESIS
  a_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    pop |=> !pop)
    else $error("request popped while the previous one is still in the table stage");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_idx) == IDX_W'(TABLE_ENTRIES - 1))
    else $error("clearing pass ended before the last entry");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !busy && !out_valid)
    else $error("request in flight during the clearing pass");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid && !busy)
    else $error("finished request did not reach the result register");
`endif

endmodule

[hdl/hashed_reuse_predictor_table_unit.sv]
// Top level of the hashed reuse predictor table.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------
//  request  | in_valid  | in_stall  | in_data  (op, pc)
//  result   | out_valid | out_stall | out_data (reuse_predicted, counter_value)
//
// In the front end a request is accepted, then hashed in HASH_STEPS steps of 8 CRC
// rounds each, reduced by the table size in MOD_STEPS steps and pushed into the queue.
// The table stage reads the entry when it pops a request, then updates and writes
// it back, overlapped with the next request's hashing. After reset a clearing pass
// over all TABLE_ENTRIES entries resets the valid bits; in_stall stays high until it ends.
// A stalled result holds the table stage; the queue then fills and stalls input.
module hashed_reuse_predictor_table_unit
  import hrp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048,
  parameter int COUNTER_MAX   = 31
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int Q_W   = OP_W + IDX_W;

  logic             clearing;
  fifo_status_t     q_stat;
  logic             q_push;
  logic             q_pop;
  logic [OP_W-1:0]  f_op;
  logic [IDX_W-1:0] f_idx;
  logic [Q_W-1:0]   q_out;

  hrp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_op     (f_op),
    .q_idx    (f_idx)
  );

  hrp_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_op, f_idx}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  hrp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNTER_MAX  (COUNTER_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_op      (q_out[Q_W-1 -: OP_W]),
    .q_idx     (q_out[IDX_W-1:0]),
    .pop       (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
